/* rtl/core/bmhpq_pkg.sv */
// ---------------------------------------------------------------------------
// Binary max-heap priority queue package
// Shared sizes, transaction codes and sequencer states.
// ---------------------------------------------------------------------------
package bmhpq_pkg;

   localparam int CAPACITY      = 128;
   localparam int PRIORITY_BITS = 16;
   localparam int PAYLOAD_BITS  = 16;
   localparam int COUNT_BITS    = 8;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [1:0] STATUS_DEQUEUED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_COMPARE,
      ST_DN_ROOT,
      ST_DN_LAST,
      ST_DN_LOAD,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_COMPARE,
      ST_FINISH
   } state_type;

endpackage

/* rtl/core/binary_max_heap_priority_queue_top.sv */
// ---------------------------------------------------------------------------
// Binary max-heap priority queue
// Heap of signed priorities with payload tags in one synchronous memory.
// ---------------------------------------------------------------------------
// Each request transaction either enqueues an entry or dequeues the entry of
// highest priority, and each yields exactly one response transaction carrying
// a status, the dequeued entry and the entry count. Requests are taken one at
// a time; a new request is accepted while the previous response still waits.
// The heap lives in one memory with a write port and a registered read port,
// so the walk is paced by its reads: an enqueue reads one parent per level it
// climbs, a dequeue reads the root, the last entry and both children per level
// it sinks. Full and empty cases go straight to the response.
module binary_max_heap_priority_queue_top #(
   parameter int CAPACITY      = bmhpq_pkg::CAPACITY,
   parameter int PRIORITY_BITS = bmhpq_pkg::PRIORITY_BITS,
   parameter int PAYLOAD_BITS  = bmhpq_pkg::PAYLOAD_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // priority_req, payload_tag
   input  logic [((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_priority, out_payload, entry_count
   output logic [((PRIORITY_BITS + PAYLOAD_BITS + bmhpq_pkg::COUNT_BITS + 7) / 8) * 8 - 1:0]
      rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);

   localparam int EW  = PRIORITY_BITS + PAYLOAD_BITS;
   localparam int NW  = bmhpq_pkg::COUNT_BITS;
   localparam int OW  = ((EW + NW + 7) / 8) * 8;
   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int LW  = AW + 2;
   localparam int CXW = (CW > NW) ? CW : NW;

   logic [EW-1:0] heap_mem [CAPACITY];
   logic [EW-1:0] mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [EW-1:0] mem_wd;
   logic [AW-1:0] mem_ra;

   bmhpq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [EW-1:0] item_ff, item_in;
   logic [EW-1:0] left_ff, left_in;
   logic [EW-1:0] top_ff, top_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   logic          req_fire;
   logic          rsp_free;
   logic [AW-1:0] parent_idx;
   logic [LW-1:0] left_idx;
   logic [LW-1:0] right_idx;
   logic [LW-1:0] count_w;
   logic          left_ok;
   logic          right_ok;
   logic          left_wins;
   logic          right_wins;
   logic [EW-1:0] cur_best;
   logic [CXW-1:0] count_x;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= heap_mem[mem_ra];
   end

   assign req_tready = (state_ff == bmhpq_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + LW'(1);
   assign count_w    = LW'(count_ff);
   assign left_ok    = left_idx < count_w;
   assign right_ok   = right_idx < count_w;

   assign left_wins  = $signed(left_ff[EW-1:PAYLOAD_BITS]) > $signed(item_ff[EW-1:PAYLOAD_BITS]);
   assign cur_best   = left_wins ? left_ff : item_ff;
   assign right_wins = right_ok &&
      ($signed(mem_q_ff[EW-1:PAYLOAD_BITS]) > $signed(cur_best[EW-1:PAYLOAD_BITS]));

   assign count_x = CXW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      item_in      = item_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_wa       = pos_ff;
      mem_wd       = item_ff;
      mem_ra       = '0;

      case (state_ff)
         bmhpq_pkg::ST_IDLE: begin
            if (req_fire) begin
               top_in  = '0;
               item_in = {req_tdata[PRIORITY_BITS-1:0], req_tdata[EW-1:PRIORITY_BITS]};
               if (req_tuser[0] == bmhpq_pkg::MODE_ENQUEUE) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = bmhpq_pkg::STATUS_FULL;
                     state_in  = bmhpq_pkg::ST_FINISH;
                  end else begin
                     status_in = bmhpq_pkg::STATUS_ENQUEUED;
                     pos_in    = count_ff[AW-1:0];
                     count_in  = count_ff + CW'(1);
                     state_in  = bmhpq_pkg::ST_UP_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = bmhpq_pkg::STATUS_EMPTY;
                     state_in  = bmhpq_pkg::ST_FINISH;
                  end else begin
                     status_in = bmhpq_pkg::STATUS_DEQUEUED;
                     count_in  = count_ff - CW'(1);
                     state_in  = bmhpq_pkg::ST_DN_ROOT;
                  end
               end
            end
         end
         bmhpq_pkg::ST_UP_READ: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = bmhpq_pkg::ST_FINISH;
            end else begin
               mem_ra   = parent_idx;
               state_in = bmhpq_pkg::ST_UP_COMPARE;
            end
         end
         bmhpq_pkg::ST_UP_COMPARE: begin
            mem_we = 1'b1;
            if ($signed(item_ff[EW-1:PAYLOAD_BITS]) > $signed(mem_q_ff[EW-1:PAYLOAD_BITS])) begin
               mem_wd   = mem_q_ff;
               pos_in   = parent_idx;
               state_in = bmhpq_pkg::ST_UP_READ;
            end else begin
               state_in = bmhpq_pkg::ST_FINISH;
            end
         end
         bmhpq_pkg::ST_DN_ROOT: begin
            mem_ra   = '0;
            state_in = bmhpq_pkg::ST_DN_LAST;
         end
         bmhpq_pkg::ST_DN_LAST: begin
            top_in   = mem_q_ff;
            mem_ra   = count_ff[AW-1:0];
            state_in = bmhpq_pkg::ST_DN_LOAD;
         end
         bmhpq_pkg::ST_DN_LOAD: begin
            item_in = mem_q_ff;
            pos_in  = '0;
            if (count_ff == '0) begin
               state_in = bmhpq_pkg::ST_FINISH;
            end else begin
               state_in = bmhpq_pkg::ST_DN_LEFT;
            end
         end
         bmhpq_pkg::ST_DN_LEFT: begin
            if (left_ok) begin
               mem_ra   = left_idx[AW-1:0];
               state_in = bmhpq_pkg::ST_DN_RIGHT;
            end else begin
               mem_we   = 1'b1;
               state_in = bmhpq_pkg::ST_FINISH;
            end
         end
         bmhpq_pkg::ST_DN_RIGHT: begin
            left_in  = mem_q_ff;
            mem_ra   = right_ok ? right_idx[AW-1:0] : '0;
            state_in = bmhpq_pkg::ST_DN_COMPARE;
         end
         bmhpq_pkg::ST_DN_COMPARE: begin
            mem_we = 1'b1;
            if (right_wins) begin
               mem_wd   = mem_q_ff;
               pos_in   = right_idx[AW-1:0];
               state_in = bmhpq_pkg::ST_DN_LEFT;
            end else if (left_wins) begin
               mem_wd   = left_ff;
               pos_in   = left_idx[AW-1:0];
               state_in = bmhpq_pkg::ST_DN_LEFT;
            end else begin
               state_in = bmhpq_pkg::ST_FINISH;
            end
         end
         bmhpq_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = OW'({count_x[NW-1:0], top_ff[PAYLOAD_BITS-1:0],
                                   top_ff[EW-1:PAYLOAD_BITS]});
               state_in     = bmhpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmhpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmhpq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      item_ff     <= item_in;
      left_ff     <= left_in;
      top_ff      <= top_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/core/bmhpq_checker.sv */
// ---------------------------------------------------------------------------
// Binary max-heap priority queue checker
// Port-level checks of the response channel, bound to the top level.
// ---------------------------------------------------------------------------
module bmhpq_checker #(
   parameter int CAPACITY      = bmhpq_pkg::CAPACITY,
   parameter int PRIORITY_BITS = bmhpq_pkg::PRIORITY_BITS,
   parameter int PAYLOAD_BITS  = bmhpq_pkg::PAYLOAD_BITS
) (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((PRIORITY_BITS + PAYLOAD_BITS + bmhpq_pkg::COUNT_BITS + 7) / 8) * 8 - 1:0]
      rsp_tdata,
   input logic [1:0] rsp_tuser
);

   localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;
   localparam int NW = bmhpq_pkg::COUNT_BITS;
   localparam int CXW = ($clog2(CAPACITY + 1) > NW) ? $clog2(CAPACITY + 1) : NW;
   localparam logic [CXW-1:0] CAP_X = CXW'(CAPACITY);

   logic [NW-1:0] entry_count;
   assign entry_count = rsp_tdata[EW+NW-1:EW];

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_zero_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != bmhpq_pkg::STATUS_DEQUEUED |-> rsp_tdata[EW-1:0] == '0)
      else $error("entry fields not zero outside dequeue");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bmhpq_pkg::STATUS_EMPTY |-> entry_count == '0)
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bmhpq_pkg::STATUS_FULL |-> entry_count == CAP_X[NW-1:0])
      else $error("full status with wrong count");

endmodule

bind binary_max_heap_priority_queue_top bmhpq_checker #(
   .CAPACITY      (CAPACITY),
   .PRIORITY_BITS (PRIORITY_BITS),
   .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_bmhpq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
